### sv/agpc_pkg.sv
// Package for the axle group pattern classifier: codes, limits and pattern table.
package agpc_pkg;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_GROUP_SPACING = 1'b0,
		REG_CAR_WEIGHT    = 1'b1
	} cfg_reg_t;

	typedef logic [3:0] grp_size_t;
	typedef logic [6:0] class_t;

	localparam int SPACING_W = 16;
	localparam int WEIGHT_W  = 20;
	localparam int CFG_W     = 20;
	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 16;

	localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd2100;
	localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET  = 20'd34334;

	localparam class_t    CLASS_CAR      = 7'd0;
	localparam class_t    CLASS_DEFAULT  = 7'd99;
	localparam class_t    CLASS_PAT_LAST = 7'd7;
	localparam grp_size_t GROUP_SIZE_MAX = 4'd15;

	localparam int PAT_TOTAL = 7;
	localparam int PAT_LEN_MAX = 4;

	// Number of groups in pattern p
	function automatic logic [2:0] pat_len(input logic [2:0] p);
		logic [2:0] len;
		unique case (p)
			3'd0:    len = 3'd2;
			3'd1:    len = 3'd3;
			3'd2:    len = 3'd2;
			3'd3:    len = 3'd4;
			3'd4:    len = 3'd3;
			3'd5:    len = 3'd3;
			3'd6:    len = 3'd3;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	// Group size at position k of pattern p
	function automatic grp_size_t pat_elem(input logic [2:0] p, input logic [1:0] k);
		grp_size_t s;
		unique case ({p, k})
			{3'd0, 2'd0}: s = 4'd1;
			{3'd0, 2'd1}: s = 4'd1;
			{3'd1, 2'd0}: s = 4'd1;
			{3'd1, 2'd1}: s = 4'd2;
			{3'd1, 2'd2}: s = 4'd3;
			{3'd2, 2'd0}: s = 4'd1;
			{3'd2, 2'd1}: s = 4'd2;
			{3'd3, 2'd0}: s = 4'd1;
			{3'd3, 2'd1}: s = 4'd2;
			{3'd3, 2'd2}: s = 4'd3;
			{3'd3, 2'd3}: s = 4'd3;
			{3'd4, 2'd0}: s = 4'd1;
			{3'd4, 2'd1}: s = 4'd2;
			{3'd4, 2'd2}: s = 4'd2;
			{3'd5, 2'd0}: s = 4'd1;
			{3'd5, 2'd1}: s = 4'd1;
			{3'd5, 2'd2}: s = 4'd2;
			{3'd6, 2'd0}: s = 4'd1;
			{3'd6, 2'd1}: s = 4'd1;
			{3'd6, 2'd2}: s = 4'd3;
			default:      s = 4'd0;
		endcase
		return s;
	endfunction

endpackage

### sv/axle_group_pattern_classifier_unit.sv
// Top level of the axle group pattern classifier.
//
// Usage:
//   One slave transaction per axle of a vehicle, in order. s_tdata carries the
//   spacing to the next axle and the gross weight; s_tlast marks the final axle.
//   On the final axle the block emits one master transaction with the class,
//   the axle count and the group count. Other axles produce nothing.
//   Configuration (group spacing limit, car weight limit) is written through
//   cfg_we / cfg_index / cfg_wdata while no vehicle is in flight.
// Pipeline and throughput:
//   An axle is registered in the input register at acceptance; a final axle's
//   result goes to the result register when the axle is processed. One axle
//   per cycle is sustained unless a final axle waits on a stalled result. All
//   per-axle work (compares, counter updates, pattern match) lies between the two.
// Reset:
//   arst_n clears the vehicle state, both pipeline valids and loads the
//   register defaults (2100 mm, 34334 thousandths).
// Stall:
//   While a result waits on m_tready the input stage keeps advancing through
//   non-final axles; a final axle behind the waiting result holds the input
//   register, and s_tready then drops until the result is taken.
module axle_group_pattern_classifier_unit #(
	parameter int MAX_AXLES     = 16,
	parameter int MAX_GROUPS    = 8,
	parameter int PATTERN_COUNT = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [agpc_pkg::IN_DATA_W-1:0]    s_tdata,  // spacing_to_next[15:0], gross_weight[35:16], zero pad
	input  logic                              s_tlast,  // last_axle
	// master stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [agpc_pkg::OUT_DATA_W-1:0]   m_tdata,  // class_id[6:0], axles_seen[11:7], groups_seen[15:12]
	// configuration write port
	input  logic                              cfg_we,
	input  agpc_pkg::cfg_reg_t                cfg_index,
	input  logic [agpc_pkg::CFG_W-1:0]        cfg_wdata
);

	localparam int IDX_W = $clog2(MAX_GROUPS);

	// Configuration registers
	logic [agpc_pkg::SPACING_W-1:0] spacing_limit_q;
	logic [agpc_pkg::WEIGHT_W-1:0]  weight_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_limit_q <= agpc_pkg::SPACING_RESET;
			weight_limit_q  <= agpc_pkg::WEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				agpc_pkg::REG_GROUP_SPACING: spacing_limit_q <= cfg_wdata[agpc_pkg::SPACING_W-1:0];
				agpc_pkg::REG_CAR_WEIGHT:    weight_limit_q  <= cfg_wdata;
			endcase
		end
	end

	// Input register stage
	logic                           vld_s1;
	logic [agpc_pkg::SPACING_W-1:0] spacing_s1;
	logic [agpc_pkg::WEIGHT_W-1:0]  weight_s1;
	logic                           last_s1;
	logic                           out_free;
	logic                           proc;

	// non-final axles need no result slot
	assign out_free = !m_tvalid || m_tready;
	assign proc     = vld_s1 && (!last_s1 || out_free);
	assign s_tready = !vld_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			spacing_s1 <= s_tdata[agpc_pkg::SPACING_W-1:0];
			weight_s1  <= s_tdata[agpc_pkg::SPACING_W +: agpc_pkg::WEIGHT_W];
			last_s1    <= s_tlast;
		end
	end

	// Vehicle state
	logic [4:0]          axle_q;
	agpc_pkg::grp_size_t cur_q;
	logic [3:0]          grp_q;
	logic                ovf_q;
	agpc_pkg::grp_size_t sizes_q [MAX_GROUPS];

	// Next-state logic for the axle in the input register
	logic [4:0]          axle_nx;
	agpc_pkg::grp_size_t cur_nx;
	logic [3:0]          grp_nx;
	logic                ovf_nx;
	logic                close;
	logic                room;
	logic                store;
	agpc_pkg::grp_size_t view [agpc_pkg::PAT_LEN_MAX];

	always_comb begin
		close   = last_s1 || (spacing_s1 >= spacing_limit_q);
		room    = grp_q < 4'(MAX_GROUPS);
		store   = close && room;
		axle_nx = (axle_q < 5'(MAX_AXLES)) ? axle_q + 5'd1 : axle_q;
		ovf_nx  = ovf_q || (axle_q >= 5'(MAX_AXLES)) || (close && !room);
		grp_nx  = store ? grp_q + 4'd1 : grp_q;
		if (close)
			cur_nx = 4'd1;
		else if (cur_q < agpc_pkg::GROUP_SIZE_MAX)
			cur_nx = cur_q + 4'd1;
		else
			cur_nx = cur_q;
		// group sizes as they stand after this axle's group is closed
		for (int k = 0; k < agpc_pkg::PAT_LEN_MAX; k++) begin
			view[k] = (store && grp_q == 4'(k)) ? cur_q : sizes_q[k];
		end
	end

	// Pattern match; the first pattern in table order wins
	agpc_pkg::class_t match_cls;
	agpc_pkg::class_t cls;

	always_comb begin
		logic       hit;
		logic [2:0] len;
		match_cls = agpc_pkg::CLASS_DEFAULT;
		for (int p = PATTERN_COUNT - 1; p >= 0; p--) begin
			len = agpc_pkg::pat_len(3'(p));
			hit = (grp_nx == 4'(len));
			for (int k = 0; k < agpc_pkg::PAT_LEN_MAX; k++) begin
				if (3'(k) < len && view[k] != agpc_pkg::pat_elem(3'(p), 2'(k)))
					hit = 1'b0;
			end
			if (hit)
				match_cls = 7'(p + 1);
		end
	end

	always_comb begin
		priority if (ovf_nx)
			cls = agpc_pkg::CLASS_DEFAULT;
		else if (axle_nx == 5'd2 && weight_s1 < weight_limit_q)
			cls = agpc_pkg::CLASS_CAR;
		else
			cls = match_cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axle_q <= '0;
			cur_q  <= 4'd1;
			grp_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (proc) begin
			if (last_s1) begin
				axle_q <= '0;
				cur_q  <= 4'd1;
				grp_q  <= '0;
				ovf_q  <= 1'b0;
			end else begin
				axle_q <= axle_nx;
				cur_q  <= cur_nx;
				grp_q  <= grp_nx;
				ovf_q  <= ovf_nx;
			end
		end
	end

	// Group size store, written as groups close
	always_ff @(posedge clk) begin
		if (proc && store)
			sizes_q[grp_q[IDX_W-1:0]] <= cur_q;
	end

	// Result register
	logic                               res_vld_q;
	logic [agpc_pkg::OUT_DATA_W-1:0]    res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (out_free) begin
			res_vld_q <= proc && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1)
			res_q <= {grp_nx, axle_nx, cls};
	end

	assign m_tvalid = res_vld_q;
	assign m_tdata  = res_q;

endmodule

### sv/agpc_checker.sv
// Port-level checker for the axle group pattern classifier, bound to the top level.
module agpc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [agpc_pkg::OUT_DATA_W-1:0] m_tdata
);

	// A stalled result holds its data
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Input backpressure only while a result is stalled
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output stall");

	// Class is the car code, a pattern number or the default code
	a_cls: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:0] <= agpc_pkg::CLASS_PAT_LAST ||
			m_tdata[6:0] == agpc_pkg::CLASS_DEFAULT))
		else $error("class out of range");

	// A car has two axles and at least one group
	a_car: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6:0] == agpc_pkg::CLASS_CAR |->
			m_tdata[11:7] == 5'd2 && m_tdata[15:12] != 4'd0)
		else $error("car result with wrong counts");

endmodule

bind axle_group_pattern_classifier_unit agpc_checker u_agpc_checker (.*);

### tb/sv/axle_group_pattern_classifier_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the axle group pattern classifier unit.
module axle_group_pattern_classifier_unit_tb;
	import agpc_pkg::*;

	localparam int MAX_AXLES       = 16;
	localparam int MAX_GROUPS      = 8;
	localparam int N_PATTERNS      = 7;
	localparam int HOLD_OFF_CYCLES = 300;   // receiver back-pressure burst
	localparam int DRAIN_CYCLES    = 8;     // idle margin after the last result comes back
	localparam int PHASE_AXLES     = 200;

	// Pattern table: group count per pattern, and group sizes as nibbles,
	// first group in the low nibble. Class is pattern index + 1.
	localparam logic [N_PATTERNS*3-1:0] PAT_GROUPS =
		{3'd3, 3'd3, 3'd3, 3'd4, 3'd2, 3'd3, 3'd2};
	localparam logic [N_PATTERNS*16-1:0] PAT_SIZES =
		{16'h0311, 16'h0211, 16'h0221, 16'h3321, 16'h0021, 16'h0321, 16'h0011};

	typedef struct {
		logic [SPACING_W-1:0] spacing;
		logic [WEIGHT_W-1:0]  weight;
		logic                 last;
	} axle_t;

	typedef struct {
		class_t     cls;
		logic [4:0] axles;
		logic [3:0] groups;
	} vehicle_class_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	cfg_reg_t              cfg_index = REG_GROUP_SPACING;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	// Shadow registers and vehicle state of the predictor
	logic [SPACING_W-1:0] spacing_limit = SPACING_RESET;
	logic [WEIGHT_W-1:0]  car_limit     = WEIGHT_RESET;
	logic [4:0]           axle_cnt      = '0;
	logic [3:0]           cur_size      = 4'd1;
	logic [3:0]           group_sizes [MAX_GROUPS];
	logic [3:0]           group_cnt     = '0;
	logic                 overflow      = 1'b0;

	axle_t          axle_q[$];          // axles waiting for the driver
	vehicle_class_t class_exp_q[$];     // predicted classifications, oldest first
	axle_t          axle_on_bus;
	vehicle_class_t want_class;

	int   axles_pushed = 0;
	int   axles_taken  = 0;
	int   classes_seen = 0;
	int   fail_count   = 0;
	int   stall_left   = 0;
	logic hold_off_go  = 1'b0;

	// Idle-free stretches on each side
	wire steady_send = (axles_taken >= 400) && (axles_taken < 600);
	wire steady_recv = (classes_seen >= 60) && (classes_seen < 120);

	axle_group_pattern_classifier_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void close_group();
		if (group_cnt < MAX_GROUPS) begin
			group_sizes[group_cnt[2:0]] = cur_size;
			group_cnt = group_cnt + 4'd1;
		end else begin
			overflow = 1'b1;
		end
		cur_size = 4'd1;
	endfunction

	// Element-wise compare of the stored group sizes against each pattern
	function automatic class_t match_groups();
		class_t cls;
		logic   same;
		cls = CLASS_DEFAULT;
		for (int p = N_PATTERNS - 1; p >= 0; p--) begin
			same = (group_cnt == PAT_GROUPS[p*3 +: 3]);
			for (int k = 0; k < 4; k++)
				if (same && k < group_cnt && group_sizes[k] != PAT_SIZES[p*16 + k*4 +: 4])
					same = 1'b0;
			if (same)
				cls = class_t'(p + 1);
		end
		return cls;
	endfunction

	// Advance the vehicle state by one axle; the last axle yields a class
	function automatic void take_axle(axle_t a);
		vehicle_class_t r;
		if (axle_cnt < MAX_AXLES)
			axle_cnt = axle_cnt + 5'd1;
		else
			overflow = 1'b1;
		if (!a.last) begin
			if (a.spacing < spacing_limit) begin
				if (cur_size < GROUP_SIZE_MAX)
					cur_size = cur_size + 4'd1;
			end else begin
				close_group();
			end
		end else begin
			close_group();
			if (overflow)
				r.cls = CLASS_DEFAULT;
			else if (axle_cnt == 5'd2 && a.weight < car_limit)
				r.cls = CLASS_CAR;
			else
				r.cls = match_groups();
			r.axles  = axle_cnt;
			r.groups = group_cnt;
			class_exp_q.insert(class_exp_q.size(), r);
			axle_cnt  = '0;
			cur_size  = 4'd1;
			group_cnt = '0;
			overflow  = 1'b0;
		end
	endfunction

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				take_axle(axle_on_bus);
				axles_taken++;
			end
			// valid stays up until the transaction completes
			if (!s_tvalid || s_tready) begin
				if (axle_q.size() != 0 && (steady_send || $urandom_range(99, 0) >= 7)) begin
					axle_on_bus = axle_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {4'b0, axle_on_bus.weight, axle_on_bus.spacing};
					s_tlast  <= axle_on_bus.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				classes_seen++;
				if (class_exp_q.size() == 0) begin
					$error("unexpected result: class_id %0d axles_seen %0d groups_seen %0d",
						m_tdata[6:0], m_tdata[11:7], m_tdata[15:12]);
					fail_count++;
				end else begin
					want_class = class_exp_q.pop_front();
					if (m_tdata[6:0] !== want_class.cls) begin
						$error("class_id: expected %0d, actual %0d", want_class.cls, m_tdata[6:0]);
						fail_count++;
					end
					if (m_tdata[11:7] !== want_class.axles) begin
						$error("axles_seen: expected %0d, actual %0d",
							want_class.axles, m_tdata[11:7]);
						fail_count++;
					end
					if (m_tdata[15:12] !== want_class.groups) begin
						$error("groups_seen: expected %0d, actual %0d",
							want_class.groups, m_tdata[15:12]);
						fail_count++;
					end
				end
			end
			// long hold-off on request, else random 7% stalls
			if (hold_off_go) begin
				stall_left <= HOLD_OFF_CYCLES;
				m_tready   <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else begin
				m_tready <= steady_recv || ($urandom_range(99, 0) >= 7);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic logic [SPACING_W-1:0] joined_gap();
		logic [SPACING_W-1:0] s;
		s = (spacing_limit == 0) ? '0 : SPACING_W'($urandom_range(spacing_limit - 1, 0));
		return s;
	endfunction

	function automatic logic [SPACING_W-1:0] split_gap();
		logic [SPACING_W-1:0] s;
		s = SPACING_W'($urandom_range(16'hFFFF, spacing_limit));
		return s;
	endfunction

	// Weights clustered on the car limit, plus the full range
	function automatic logic [WEIGHT_W-1:0] pick_weight();
		logic [WEIGHT_W-1:0] w;
		case ($urandom_range(3, 0))
			0:       w = WEIGHT_W'(car_limit - $urandom_range(3, 1));
			1:       w = WEIGHT_W'(car_limit + $urandom_range(3, 0));
			default: w = WEIGHT_W'($urandom);
		endcase
		return w;
	endfunction

	task automatic push_axle(input logic [SPACING_W-1:0] spacing,
			input logic [WEIGHT_W-1:0] weight, input logic last);
		axle_t a;
		a.spacing = spacing;
		a.weight  = weight;
		a.last    = last;
		axle_q.insert(axle_q.size(), a);
		axles_pushed++;
	endtask

	// One vehicle from a list of group sizes, one byte per group, first group lowest
	task automatic push_vehicle(input int n_groups, input logic [127:0] sizes,
			input logic [WEIGHT_W-1:0] weight);
		int g, k, n;
		for (g = 0; g < n_groups; g++) begin
			n = int'(sizes[g*8 +: 8]);
			for (k = 0; k < n; k++) begin
				if (g == n_groups - 1 && k == n - 1)
					push_axle(SPACING_W'($urandom), weight, 1'b1);
				else if (k == n - 1)
					push_axle(split_gap(), WEIGHT_W'($urandom), 1'b0);
				else
					push_axle(joined_gap(), WEIGHT_W'($urandom), 1'b0);
			end
		end
	endtask

	task automatic random_vehicles(input int n_axles);
		int start, kind, n_groups, g, p, k;
		logic [127:0] sizes;
		start = axles_pushed;
		while (axles_pushed - start < n_axles) begin
			sizes = '0;
			kind  = $urandom_range(99, 0);
			if (kind < 35) begin
				// known pattern
				p = $urandom_range(N_PATTERNS - 1, 0);
				n_groups = int'(PAT_GROUPS[p*3 +: 3]);
				for (g = 0; g < n_groups; g++)
					sizes[g*8 +: 8] = 8'(PAT_SIZES[p*16 + g*4 +: 4]);
			end else if (kind < 50) begin
				// two-axle vehicle, car or not
				n_groups = $urandom_range(2, 1);
				sizes = (n_groups == 1) ? 128'h02 : 128'h0101;
			end else if (kind < 70) begin
				n_groups = $urandom_range(5, 1);
				for (g = 0; g < n_groups; g++)
					sizes[g*8 +: 8] = 8'($urandom_range(4, 1));
			end else if (kind < 78) begin
				// more groups than can be stored
				n_groups = $urandom_range(11, 9);
				for (g = 0; g < n_groups; g++)
					sizes[g*8 +: 8] = 8'($urandom_range(2, 1));
			end else if (kind < 86) begin
				// axle count around and past the limit
				n_groups = $urandom_range(5, 3);
				for (g = 0; g < n_groups; g++)
					sizes[g*8 +: 8] = 8'($urandom_range(6, 4));
			end else if (kind < 92) begin
				// group size at and past saturation
				n_groups = $urandom_range(2, 1);
				for (g = 0; g < n_groups; g++)
					sizes[g*8 +: 8] = 8'($urandom_range(17, 13));
			end else begin
				// noise: arbitrary axles, random last flags
				n_groups = 0;
				for (k = $urandom_range(6, 1); k > 0; k--)
					push_axle(SPACING_W'($urandom), WEIGHT_W'($urandom),
						$urandom_range(3, 0) == 0);
			end
			if (n_groups != 0)
				push_vehicle(n_groups, sizes, pick_weight());
		end
		// close any vehicle left open by noise
		push_axle(SPACING_W'($urandom), WEIGHT_W'($urandom), 1'b1);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_GROUP_SPACING)
			spacing_limit = val[SPACING_W-1:0];
		else
			car_limit = val[WEIGHT_W-1:0];
	endtask

	task automatic set_limits(input logic [SPACING_W-1:0] spacing,
			input logic [WEIGHT_W-1:0] weight);
		write_reg(REG_GROUP_SPACING, CFG_W'(spacing));
		write_reg(REG_CAR_WEIGHT, weight);
	endtask

	// Sender holds until every axle is taken and every class has come back
	task automatic wait_idle();
		while (axles_taken != axles_pushed || class_exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset limits, field extremes, car and non-car, single axle
		push_axle(16'h0000, 20'hFFFFF, 1'b0);       // car: one group of two, weight 0
		push_axle(16'hFFFF, 20'h00000, 1'b1);
		push_axle(16'hFFFF, 20'h00000, 1'b0);       // heavy two-axle, pattern 1-1
		push_axle(16'h0000, 20'hFFFFF, 1'b1);
		push_vehicle(2, 128'h0101, car_limit);      // weight equal to the car limit
		push_axle(SPACING_W'($urandom), WEIGHT_W'($urandom), 1'b1);  // single-axle vehicle
		push_vehicle(2, 128'h0201, WEIGHT_W'($urandom));     // 1-2
		push_vehicle(3, 128'h020201, WEIGHT_W'($urandom));   // 1-2-2
		push_vehicle(3, 128'h020101, WEIGHT_W'($urandom));   // 1-1-2
		push_vehicle(3, 128'h030101, WEIGHT_W'($urandom));   // 1-1-3
		random_vehicles(PHASE_AXLES);

		// Both limits at zero: no joins, never a car
		wait_idle();
		set_limits('0, '0);
		random_vehicles(PHASE_AXLES);

		// Both limits at maximum, opened with a long receiver hold-off so the
		// unit fills and back-pressures the sender
		wait_idle();
		set_limits(16'hFFFF, 20'hFFFFF);
		@(posedge clk);
		hold_off_go <= 1'b1;
		for (int v = 0; v < 40; v++)
			push_vehicle(2, 128'h0101, pick_weight());
		@(posedge clk);
		hold_off_go <= 1'b0;
		random_vehicles(PHASE_AXLES);

		wait_idle();
		set_limits(SPACING_W'($urandom_range(5000, 500)),
			WEIGHT_W'($urandom_range(200000, 1000)));
		random_vehicles(PHASE_AXLES);

		wait_idle();
		set_limits(SPACING_RESET, WEIGHT_RESET);
		random_vehicles(PHASE_AXLES);

		wait_idle();
		if (fail_count == 0)
			$display("axle_group_pattern_classifier_unit test passed");
		else
			$display("axle_group_pattern_classifier_unit test failed");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("axle_group_pattern_classifier_unit test failed");
		$finish;
	end

endmodule
